>>> src/lpht_pkg.sv
// shared types, codes and helpers for the linear probe hash table
// no dependencies; used by the interfaces, the hash unit and the top level
package lpht_pkg;

    // widths fixed by the field formats
    localparam int unsigned CAP_W      = 7;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 7;

    // register reset values
    localparam logic [CAP_W-1:0] CAPACITY_RST = 7'd64;
    localparam logic [LEN_W-1:0] MAX_KLEN_RST = 4'd8;
    localparam logic [LEN_W-1:0] MAX_PLEN_RST = 4'd8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_UPDATE = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_KEY_LONG  = 3'd2,
        ST_PAY_LONG  = 3'd3,
        ST_EXISTS    = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CAPACITY     = 2'd0,
        CFG_MAX_KEY_LEN  = 2'd1,
        CFG_MAX_PAY_LEN  = 2'd2
    } t_cfg_idx;

    // hash unit status toward the sequencer
    typedef struct packed {
        logic             done;
        logic [CAP_W-1:0] home;
    } t_hash_st;

    // mask keeping the low len bytes of a word
    function automatic logic [WORD_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [WORD_W-1:0] m;
        if (len >= 4'd8) begin
            m = '1;
        end else begin
            m = (WORD_W'(1) << {len[2:0], 3'b000}) - WORD_W'(1);
        end
        return m;
    endfunction

endpackage

>>> src/lpht_in_if.sv
// command channel: operation, key and payload words
// depends on lpht_pkg for field widths
interface lpht_in_if;
    logic                             valid;
    logic                             ready;
    logic [lpht_pkg::FUNC_W-1:0]      func;
    logic [lpht_pkg::WORD_W-1:0]      key;
    logic [lpht_pkg::LEN_W-1:0]       key_length;
    logic [lpht_pkg::WORD_W-1:0]      payload;
    logic [lpht_pkg::LEN_W-1:0]       payload_length;

    modport source (output valid, func, key, key_length, payload, payload_length,
                    input ready);
    modport sink   (input valid, func, key, key_length, payload, payload_length,
                    output ready);
endinterface

>>> src/lpht_out_if.sv
// response channel: status, found payload and entry count
// depends on lpht_pkg for field widths
interface lpht_out_if;
    logic                             valid;
    logic                             ready;
    logic [lpht_pkg::STATUS_W-1:0]    status;
    logic [lpht_pkg::WORD_W-1:0]      found_payload;
    logic [lpht_pkg::LEN_W-1:0]       found_payload_length;
    logic [lpht_pkg::CAP_W-1:0]       entry_count;

    modport source (output valid, status, found_payload, found_payload_length, entry_count,
                    input ready);
    modport sink   (input valid, status, found_payload, found_payload_length, entry_count,
                    output ready);
endinterface

>>> src/lpht_cfg_if.sv
// configuration write channel: register index and data
// depends on lpht_pkg for field widths
interface lpht_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lpht_pkg::CFG_ADDR_W-1:0]   addr;
    logic [lpht_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

>>> src/lpht_hash.sv
// home slot unit: byte sum of the key, then restoring remainder by capacity
// depends on lpht_pkg; one byte per cycle, then one quotient bit per cycle
module lpht_hash #(
    parameter int KEY_BYTES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [KEY_BYTES*8-1:0]       i_key,
    input  logic [lpht_pkg::CAP_W-1:0]   i_cap,
    output lpht_pkg::t_hash_st           o_st
);
    localparam int KEY_W   = KEY_BYTES * 8;
    localparam int SUM_W   = $clog2(KEY_BYTES * 255 + 1);
    localparam int DIV_W   = lpht_pkg::CAP_W + SUM_W - 1;
    localparam int CNT_MAX = (KEY_BYTES > SUM_W) ? KEY_BYTES : SUM_W;
    localparam int CNT_W   = $clog2(CNT_MAX);

    typedef enum logic [1:0] {
        H_IDLE,
        H_SUM,
        H_MOD
    } t_hstate;

    t_hstate          r_state;
    logic [KEY_W-1:0] r_ksh;
    logic [SUM_W-1:0] r_sum;
    logic [DIV_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    // shared compare and subtract for the remainder steps
    logic [DIV_W-1:0] rem_ext;
    logic             rem_ge;
    assign rem_ext = DIV_W'(r_sum);
    assign rem_ge  = (rem_ext >= r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_ksh   <= i_key;
                        r_sum   <= '0;
                        r_div   <= DIV_W'(i_cap) << (SUM_W - 1);
                        r_cnt   <= CNT_W'(KEY_BYTES - 1);
                        r_state <= H_SUM;
                    end
                end
                // add one key byte per cycle
                H_SUM: begin
                    r_sum <= r_sum + SUM_W'(r_ksh[7:0]);
                    r_ksh <= r_ksh >> 8;
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(SUM_W - 1);
                        r_state <= H_MOD;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                // one restoring step per cycle
                H_MOD: begin
                    if (rem_ge) begin
                        r_sum <= SUM_W'(rem_ext - r_div);
                    end
                    r_div <= r_div >> 1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_st.done = r_done;
    assign o_st.home = lpht_pkg::CAP_W'(r_sum);

    // remainder is below the divisor once done
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (lpht_pkg::CAP_W'(r_sum) < i_cap || i_cap == '0))
        else $error("hash remainder not reduced");
    // the sum phase only leads on to the remainder phase
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == H_SUM) |=> (r_state == H_SUM || r_state == H_MOD))
        else $error("hash sum phase left early");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == H_MOD))
        else $error("hash done without remainder phase");

endmodule

>>> src/linear_probe_hash_table_unit.sv
// keyed store with open addressing and linear probing, top level
// depends on lpht_pkg, lpht_in_if, lpht_out_if, lpht_cfg_if and lpht_hash
// early rejects go from the command word straight to the response; probing ops run the hash
//   unit, then the probe loop over the slots, then the response
// the probe loop reads one slot per cycle from the slot memory
// reset: registers to defaults, then a clearing pass over every slot
//   of the slot memory during which no command word is accepted
module linear_probe_hash_table_unit #(
    parameter int TABLE_DEPTH   = 64,
    parameter int KEY_BYTES     = 8,
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpht_in_if.sink     i_cmd,
    lpht_out_if.source  o_rsp,
    lpht_cfg_if.sink    i_cfg
);
    localparam int CAP_W     = lpht_pkg::CAP_W;
    localparam int LEN_W     = lpht_pkg::LEN_W;
    localparam int WORD_W    = lpht_pkg::WORD_W;
    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int KEY_W     = KEY_BYTES * 8;
    localparam int PAY_W     = PAYLOAD_BYTES * 8;
    localparam int PAY_LO    = 0;
    localparam int PLEN_LO   = PAY_W;
    localparam int KEY_LO    = PLEN_LO + LEN_W;
    localparam int KLEN_LO   = KEY_LO + KEY_W;
    localparam int VALID_BIT = KLEN_LO + LEN_W;
    localparam int ENT_W     = VALID_BIT + 1;
    localparam int DEPTH_CAP = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;
    localparam logic [CAP_W-1:0] DEPTH_LIM = CAP_W'(DEPTH_CAP);
    localparam logic [LEN_W-1:0] KEY_LIM   = LEN_W'(KEY_BYTES);
    localparam logic [LEN_W-1:0] PAY_LIM   = LEN_W'(PAYLOAD_BYTES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_RESP
    } t_state;

    // configuration registers
    logic [CAP_W-1:0] r_capacity;
    logic [LEN_W-1:0] r_max_klen;
    logic [LEN_W-1:0] r_max_plen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lpht_pkg::CAPACITY_RST;
            r_max_klen <= lpht_pkg::MAX_KLEN_RST;
            r_max_plen <= lpht_pkg::MAX_PLEN_RST;
        end else if (i_cfg.valid) begin
            case (lpht_pkg::t_cfg_idx'(i_cfg.addr))
                lpht_pkg::CFG_CAPACITY:    r_capacity <= i_cfg.data;
                lpht_pkg::CFG_MAX_KEY_LEN: r_max_klen <= i_cfg.data[LEN_W-1:0];
                lpht_pkg::CFG_MAX_PAY_LEN: r_max_plen <= i_cfg.data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end
    assign i_cfg.ready = 1'b1;

    // effective limits
    logic [CAP_W-1:0] eff_cap;
    logic [LEN_W-1:0] kmax;
    logic [LEN_W-1:0] pmax;
    assign eff_cap = (r_capacity > DEPTH_LIM) ? DEPTH_LIM : r_capacity;
    assign kmax    = (r_max_klen < KEY_LIM) ? r_max_klen : KEY_LIM;
    assign pmax    = (r_max_plen < PAY_LIM) ? r_max_plen : PAY_LIM;

    // sequencer registers
    t_state            r_state;
    lpht_pkg::t_func   r_func;
    logic [KEY_W-1:0]  r_key;
    logic [LEN_W-1:0]  r_klen;
    logic [PAY_W-1:0]  r_pay;
    logic [LEN_W-1:0]  r_plen;
    logic [CAP_W-1:0]  r_count;
    logic [CAP_W-1:0]  r_ptr;
    logic [CAP_W-1:0]  r_issued;
    logic [CAP_W-1:0]  r_cmp_addr;
    logic              r_cmp_v;
    logic [AW-1:0]     r_clr_addr;
    logic              r_hstart;
    lpht_pkg::t_status r_status;
    logic [PAY_W-1:0]  r_fpay;
    logic [LEN_W-1:0]  r_fplen;
    logic              r_we;
    logic [AW-1:0]     r_waddr;
    logic [ENT_W-1:0]  r_wdata;
    logic [ENT_W-1:0]  r_rd;

    // response registers
    logic                  r_out_valid;
    lpht_pkg::t_status     r_out_status;
    logic [WORD_W-1:0]     r_out_fpay;
    logic [LEN_W-1:0]      r_out_fplen;
    logic [CAP_W-1:0]      r_out_count;

    // slot memory: one write and one registered read per cycle
    logic [ENT_W-1:0] r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_waddr] <= r_wdata;
        end
        r_rd <= r_mem[AW'(r_ptr)];
    end

    // hash unit
    lpht_pkg::t_hash_st hash_st;

    lpht_hash #(
        .KEY_BYTES (KEY_BYTES)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_hstart),
        .i_key   (r_key),
        .i_cap   (eff_cap),
        .o_st    (hash_st)
    );

    // slot compare on the word read last cycle
    logic             e_valid;
    logic [LEN_W-1:0] e_klen;
    logic [KEY_W-1:0] e_key;
    logic [LEN_W-1:0] e_plen;
    logic [PAY_W-1:0] e_pay;
    logic             e_match;
    logic             issue;
    logic [CAP_W-1:0] ptr_inc;
    logic             out_free;
    logic             cmd_acc;

    assign e_valid  = r_rd[VALID_BIT];
    assign e_klen   = r_rd[KLEN_LO +: LEN_W];
    assign e_key    = r_rd[KEY_LO +: KEY_W];
    assign e_plen   = r_rd[PLEN_LO +: LEN_W];
    assign e_pay    = r_rd[PAY_LO +: PAY_W];
    assign e_match  = e_valid && (e_klen == r_klen) && (e_key == r_key);
    assign issue    = (r_issued < eff_cap);
    assign ptr_inc  = r_ptr + CAP_W'(1);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign cmd_acc  = i_cmd.valid && i_cmd.ready;

    assign i_cmd.ready = (r_state == S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_we        <= 1'b0;
            r_hstart    <= 1'b0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_we     <= 1'b0;
            r_hstart <= 1'b0;
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                // zero every slot after reset
                S_CLEAR: begin
                    r_we       <= 1'b1;
                    r_waddr    <= r_clr_addr;
                    r_wdata    <= '0;
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                // take a command word and run the early checks
                S_IDLE: begin
                    if (cmd_acc) begin
                        r_func   <= lpht_pkg::t_func'(i_cmd.func);
                        r_klen   <= i_cmd.key_length;
                        r_plen   <= i_cmd.payload_length;
                        r_key    <= KEY_W'(i_cmd.key & lpht_pkg::byte_mask(i_cmd.key_length));
                        r_pay    <= PAY_W'(i_cmd.payload &
                                           lpht_pkg::byte_mask(i_cmd.payload_length));
                        r_fpay   <= '0;
                        r_fplen  <= '0;
                        r_status <= lpht_pkg::ST_OK;
                        r_state  <= S_RESP;
                        case (lpht_pkg::t_func'(i_cmd.func))
                            lpht_pkg::FUNC_INSERT: begin
                                if (r_count >= eff_cap) begin
                                    r_status <= lpht_pkg::ST_FULL;
                                end else if (i_cmd.key_length > kmax) begin
                                    r_status <= lpht_pkg::ST_KEY_LONG;
                                end else if (i_cmd.payload_length > pmax) begin
                                    r_status <= lpht_pkg::ST_PAY_LONG;
                                end else begin
                                    r_hstart <= 1'b1;
                                    r_state  <= S_HASH;
                                end
                            end
                            lpht_pkg::FUNC_UPDATE: begin
                                if (i_cmd.payload_length > pmax) begin
                                    r_status <= lpht_pkg::ST_PAY_LONG;
                                end else if (eff_cap == '0 || i_cmd.key_length > KEY_LIM) begin
                                    r_status <= lpht_pkg::ST_NOT_FOUND;
                                end else begin
                                    r_hstart <= 1'b1;
                                    r_state  <= S_HASH;
                                end
                            end
                            default: begin
                                if (eff_cap == '0 || i_cmd.key_length > KEY_LIM) begin
                                    r_status <= lpht_pkg::ST_NOT_FOUND;
                                end else begin
                                    r_hstart <= 1'b1;
                                    r_state  <= S_HASH;
                                end
                            end
                        endcase
                    end
                end
                // wait for the home slot
                S_HASH: begin
                    if (hash_st.done) begin
                        r_ptr    <= hash_st.home;
                        r_issued <= '0;
                        r_cmp_v  <= 1'b0;
                        r_state  <= S_PROBE;
                    end
                end
                // issue one slot read and compare the previous one per cycle
                S_PROBE: begin
                    r_cmp_v    <= issue;
                    r_cmp_addr <= r_ptr;
                    if (issue) begin
                        r_issued <= r_issued + CAP_W'(1);
                        r_ptr    <= (ptr_inc == eff_cap) ? '0 : ptr_inc;
                    end
                    r_waddr <= AW'(r_cmp_addr);
                    if (r_cmp_v && r_func == lpht_pkg::FUNC_INSERT && !e_valid) begin
                        r_we     <= 1'b1;
                        r_wdata  <= {1'b1, r_klen, r_key, r_plen, r_pay};
                        r_count  <= r_count + CAP_W'(1);
                        r_cmp_v  <= 1'b0;
                        r_state  <= S_RESP;
                    end else if (r_cmp_v && e_match) begin
                        r_cmp_v <= 1'b0;
                        r_state <= S_RESP;
                        case (r_func)
                            lpht_pkg::FUNC_INSERT: begin
                                r_status <= lpht_pkg::ST_EXISTS;
                            end
                            lpht_pkg::FUNC_GET: begin
                                r_fpay  <= e_pay;
                                r_fplen <= e_plen;
                            end
                            lpht_pkg::FUNC_DELETE: begin
                                r_we    <= 1'b1;
                                r_wdata <= '0;
                                if (r_count != '0) begin
                                    r_count <= r_count - CAP_W'(1);
                                end
                            end
                            default: begin
                                r_we    <= 1'b1;
                                r_wdata <= {1'b1, e_klen, e_key, r_plen, r_pay};
                            end
                        endcase
                    end else if (!r_cmp_v && !issue) begin
                        r_state  <= S_RESP;
                        r_status <= (r_func == lpht_pkg::FUNC_INSERT) ?
                                    lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
                    end
                end
                // hand the result word to the output register
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_fpay   <= WORD_W'(r_fpay);
                        r_out_fplen  <= r_fplen;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid                = r_out_valid;
    assign o_rsp.status               = r_out_status;
    assign o_rsp.found_payload        = r_out_fpay;
    assign o_rsp.found_payload_length = r_out_fplen;
    assign o_rsp.entry_count          = r_out_count;

    // occupancy never passes the slot limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_LIM)
        else $error("entry count above slot limit");
    // occupancy moves by at most one per operation
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> (r_count == $past(r_count) + CAP_W'(1) ||
                               r_count == $past(r_count) - CAP_W'(1)))
        else $error("entry count jumped");
    // slot writes come only from the clearing pass or the probe loop
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_we |-> ($past(r_state) == S_CLEAR || $past(r_state) == S_PROBE))
        else $error("slot write outside clear or probe");
    // a failed operation returns no payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != lpht_pkg::ST_OK) |->
            (r_out_fpay == '0 && r_out_fplen == '0))
        else $error("payload on failed operation");
    // hash result only arrives while waiting for it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_st.done |-> (r_state == S_HASH))
        else $error("unexpected hash result");

endmodule
